@@ rtl/aulp_pkg.sv @@
// Shared types, constants and defaults of the ASCII unsigned list parser.
package aulp_pkg;

  localparam int TOKEN_MAX_CHARS_DEF = 31;
  localparam int MAX_NUMBERS_DEF     = 8;
  localparam int LINE_BYTES_DEF      = 256;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;

  localparam int CFG_W      = 4;
  localparam int OUT_DATA_W = 48;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_TOKEN,
    PH_TOKEN_BAD,
    PH_TAIL,
    PH_REST,
    PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_FEW,
    ST_TOO_LONG,
    ST_BAD
  } status_t;

  // Classified input byte.
  typedef struct packed {
    logic       is_zero;
    logic       is_ws;
    logic       is_x;
    logic       is_dec;
    logic       is_hexl;
    logic [3:0] digit;
  } cls_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [2:0]  index;
    status_t     status;
    logic [7:0]  offset;
    logic        empty;
    logic        last;
  } res_t;

  // Up to two results from one byte; r1 is only used when v1 is set.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

@@ rtl/aulp_front.sv @@
// Front part: accepts text bytes, classifies them and queues the classes.
module aulp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] char_code
  output logic                q_valid,
  output aulp_pkg::cls_t      q_cls,
  input  logic                q_pop
);

  localparam int QW = (aulp_pkg::QUEUE_DEPTH > 1) ? $clog2(aulp_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(aulp_pkg::QUEUE_DEPTH + 1);

  aulp_pkg::cls_t cls;
  aulp_pkg::cls_t mem_r [aulp_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;
  logic           pop;

  always_comb begin
    cls         = '0;
    cls.is_zero = (in_tdata == aulp_pkg::CH_NUL);
    cls.is_ws   = (in_tdata == aulp_pkg::CH_SPACE) || (in_tdata == aulp_pkg::CH_TAB);
    cls.is_x    = (in_tdata == aulp_pkg::CH_LX) || (in_tdata == aulp_pkg::CH_UX);
    if (in_tdata >= aulp_pkg::CH_0 && in_tdata <= aulp_pkg::CH_9) begin
      cls.is_dec = 1'b1;
      cls.digit  = 4'(in_tdata - aulp_pkg::CH_0);
    end else if (in_tdata >= aulp_pkg::CH_LA && in_tdata <= aulp_pkg::CH_LF) begin
      cls.is_hexl = 1'b1;
      cls.digit   = 4'(in_tdata - aulp_pkg::CH_LA) + 4'd10;
    end else if (in_tdata >= aulp_pkg::CH_UA && in_tdata <= aulp_pkg::CH_UF) begin
      cls.is_hexl = 1'b1;
      cls.digit   = 4'(in_tdata - aulp_pkg::CH_UA) + 4'd10;
    end
  end

  assign in_tready = (count_r < CW'(aulp_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_cls     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(aulp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(aulp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/aulp_back.sv @@
// Back part: parser state machine that turns byte classes into results.
module aulp_back #(
  parameter int TOKEN_MAX_CHARS = aulp_pkg::TOKEN_MAX_CHARS_DEF,
  parameter int MAX_NUMBERS     = aulp_pkg::MAX_NUMBERS_DEF,
  parameter int LINE_BYTES      = aulp_pkg::LINE_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [aulp_pkg::CFG_W-1:0] value_count,
  input  logic                     q_valid,
  input  aulp_pkg::cls_t           q_cls,
  output logic                     q_pop,
  input  logic                     out_room,
  output aulp_pkg::push_t          push
);

  localparam int LW = $clog2(TOKEN_MAX_CHARS + 1);
  localparam int NW = $clog2(MAX_NUMBERS + 1);
  localparam int PW = $clog2(LINE_BYTES);

  aulp_pkg::phase_t  phase_r, phase_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              hex_r, hex_nxt;
  logic [LW-1:0]     dc_r, dc_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [NW-1:0]     nd_r, nd_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     saved_r, saved_nxt;
  aulp_pkg::status_t err_r, err_nxt;

  logic              step;
  logic              enter;
  aulp_pkg::phase_t  eff_phase;
  logic [31:0]       eff_acc;
  logic              eff_hex;
  logic [LW-1:0]     eff_dc;
  logic [LW-1:0]     eff_len;
  logic [LW-1:0]     len_inc;
  logic [aulp_pkg::CFG_W-1:0] cnt;
  logic              last_num;
  logic              in_token;
  logic              tok_end;
  logic              tok_ok;
  logic              is_digit;
  logic [31:0]       acc_mul;

  assign step  = q_valid && out_room;
  assign q_pop = step;

  always_comb begin
    if (value_count == '0) begin
      cnt = aulp_pkg::CFG_W'(1);
    end else if (value_count > aulp_pkg::CFG_W'(MAX_NUMBERS)) begin
      cnt = aulp_pkg::CFG_W'(MAX_NUMBERS);
    end else begin
      cnt = value_count;
    end
  end

  // A non-blank byte in the lead phase opens a token with fresh token state.
  always_comb begin
    enter     = (phase_r == aulp_pkg::PH_LEAD) && !q_cls.is_zero && !q_cls.is_ws;
    eff_phase = enter ? aulp_pkg::PH_TOKEN : phase_r;
    eff_acc   = enter ? '0 : acc_r;
    eff_hex   = enter ? 1'b0 : hex_r;
    eff_dc    = enter ? '0 : dc_r;
    eff_len   = enter ? '0 : len_r;
    len_inc   = eff_len + 1'b1;
    in_token  = (eff_phase == aulp_pkg::PH_TOKEN) || (eff_phase == aulp_pkg::PH_TOKEN_BAD);
    tok_end   = in_token && (q_cls.is_zero || q_cls.is_ws);
    tok_ok    = tok_end && (eff_phase != aulp_pkg::PH_TOKEN_BAD) && (eff_dc != '0);
    last_num  = (aulp_pkg::CFG_W'(nd_r) + aulp_pkg::CFG_W'(1)) >= cnt;
    is_digit  = q_cls.is_dec || (eff_hex && q_cls.is_hexl);
    if (eff_hex) begin
      acc_mul = {eff_acc[27:0], 4'b0000} + 32'(q_cls.digit);
    end else begin
      acc_mul = {eff_acc[28:0], 3'b000} + {eff_acc[30:0], 1'b0} + 32'(q_cls.digit);
    end
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    hex_nxt   = hex_r;
    dc_nxt    = dc_r;
    len_nxt   = len_r;
    nd_nxt    = nd_r;
    pos_nxt   = pos_r;
    saved_nxt = saved_r;
    err_nxt   = err_r;
    if (step) begin
      phase_nxt = eff_phase;
      acc_nxt   = eff_acc;
      hex_nxt   = eff_hex;
      dc_nxt    = eff_dc;
      len_nxt   = eff_len;
      case (eff_phase)
        aulp_pkg::PH_TOKEN, aulp_pkg::PH_TOKEN_BAD: begin
          if (tok_end) begin
            if (!tok_ok) begin
              err_nxt   = aulp_pkg::ST_BAD;
              phase_nxt = aulp_pkg::PH_FAILED;
            end else if (last_num) begin
              phase_nxt = aulp_pkg::PH_TAIL;
            end else begin
              nd_nxt    = nd_r + 1'b1;
              phase_nxt = aulp_pkg::PH_LEAD;
            end
          end else if (eff_len >= LW'(TOKEN_MAX_CHARS)) begin
            err_nxt   = aulp_pkg::ST_TOO_LONG;
            phase_nxt = aulp_pkg::PH_FAILED;
          end else begin
            len_nxt = len_inc;
            if (eff_phase == aulp_pkg::PH_TOKEN) begin
              // A 0x or 0X prefix switches the token to hexadecimal.
              if (q_cls.is_x && len_inc == LW'(2) && !eff_hex &&
                  eff_dc == LW'(1) && eff_acc == '0) begin
                hex_nxt = 1'b1;
                dc_nxt  = '0;
              end else if (is_digit) begin
                acc_nxt = acc_mul;
                dc_nxt  = eff_dc + 1'b1;
              end else begin
                phase_nxt = aulp_pkg::PH_TOKEN_BAD;
              end
            end
          end
        end
        aulp_pkg::PH_TAIL: begin
          if (!q_cls.is_zero && !q_cls.is_ws) begin
            saved_nxt = pos_r;
            phase_nxt = aulp_pkg::PH_REST;
          end
        end
        aulp_pkg::PH_LEAD, aulp_pkg::PH_REST, aulp_pkg::PH_FAILED: begin
        end
        default: begin
          phase_nxt = aulp_pkg::PH_LEAD;
        end
      endcase
      if (q_cls.is_zero) begin
        phase_nxt = aulp_pkg::PH_LEAD;
        acc_nxt   = '0;
        hex_nxt   = 1'b0;
        dc_nxt    = '0;
        len_nxt   = '0;
        nd_nxt    = '0;
        pos_nxt   = '0;
        saved_nxt = '0;
        err_nxt   = aulp_pkg::ST_OK;
      end else if (pos_r < PW'(LINE_BYTES - 1)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // Outputs.
  aulp_pkg::res_t    val_res;
  aulp_pkg::res_t    st_res;
  aulp_pkg::phase_t  fin_phase;
  aulp_pkg::status_t fin_err;

  always_comb begin
    val_res       = '0;
    val_res.kind  = aulp_pkg::KIND_VALUE;
    val_res.value = eff_acc;
    val_res.index = 3'(nd_r);

    fin_err = err_r;
    if (tok_end) begin
      if (!tok_ok) begin
        fin_phase = aulp_pkg::PH_FAILED;
        fin_err   = aulp_pkg::ST_BAD;
      end else begin
        fin_phase = last_num ? aulp_pkg::PH_TAIL : aulp_pkg::PH_LEAD;
      end
    end else begin
      fin_phase = eff_phase;
    end

    st_res      = '0;
    st_res.kind = aulp_pkg::KIND_STATUS;
    st_res.last = 1'b1;
    case (fin_phase)
      aulp_pkg::PH_FAILED: begin
        st_res.status = fin_err;
      end
      aulp_pkg::PH_TAIL: begin
        st_res.status = aulp_pkg::ST_OK;
        st_res.offset = 8'(pos_r);
        st_res.empty  = 1'b1;
      end
      aulp_pkg::PH_REST: begin
        st_res.status = aulp_pkg::ST_OK;
        st_res.offset = 8'(saved_r);
      end
      default: begin
        st_res.status = aulp_pkg::ST_TOO_FEW;
      end
    endcase

    push    = '0;
    push.v0 = step && (tok_ok || q_cls.is_zero);
    push.v1 = step && tok_ok && q_cls.is_zero;
    push.r0 = tok_ok ? val_res : st_res;
    push.r1 = st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aulp_pkg::PH_LEAD;
      acc_r   <= '0;
      hex_r   <= 1'b0;
      dc_r    <= '0;
      len_r   <= '0;
      nd_r    <= '0;
      pos_r   <= '0;
      saved_r <= '0;
      err_r   <= aulp_pkg::ST_OK;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      hex_r   <= hex_nxt;
      dc_r    <= dc_nxt;
      len_r   <= len_nxt;
      nd_r    <= nd_nxt;
      pos_r   <= pos_nxt;
      saved_r <= saved_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/aulp_out.sv @@
// Result buffer: takes up to two results a cycle and drives the result stream.
module aulp_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aulp_pkg::push_t                  push,
  output logic                             out_room,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] number_value, [34:32] number_index, [36:35] parse_status,
  // [44:37] rest_offset, [45] rest_empty, [47:46] zero
  output logic [aulp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,  // is_last
  output logic                             out_tuser   // [0] result_kind
);

  localparam int PTW = $clog2(aulp_pkg::OUT_DEPTH);
  localparam int CW  = $clog2(aulp_pkg::OUT_DEPTH + 1);

  aulp_pkg::res_t mem_r [aulp_pkg::OUT_DEPTH];
  logic [PTW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [PTW-1:0] wr_ptr_p1;
  logic           pop;
  logic [1:0]     n_push;
  aulp_pkg::res_t head;

  // Room is kept for the two results that one byte can cause.
  assign out_room   = (count_r <= CW'(aulp_pkg::OUT_DEPTH - 2));
  assign out_tvalid = (count_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
  assign head       = mem_r[rd_ptr_r];

  assign out_tdata = {2'b00, head.empty, head.offset, head.status, head.index, head.value};
  assign out_tlast = head.last;
  assign out_tuser = head.kind;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTW'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

@@ rtl/ascii_unsigned_list_parser_top.sv @@
// A byte's results pass through the registered byte queue and result buffer in turn.
// Throughput: one byte per cycle while the result buffer has room; a byte ending
// both a token and the string gives two results, which leave the 4-entry result
// buffer one per cycle while out_tready is high. The 2-entry byte queue and the
// 4-entry result buffer decouple input and output stalls. Reset (synchronous, rst_n
// low) empties both queues, clears the parser and sets value_count to 1.
module ascii_unsigned_list_parser_top #(
  parameter int TOKEN_MAX_CHARS = aulp_pkg::TOKEN_MAX_CHARS_DEF,
  parameter int MAX_NUMBERS     = aulp_pkg::MAX_NUMBERS_DEF,
  parameter int LINE_BYTES      = aulp_pkg::LINE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] char_code
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] number_value, [34:32] number_index, [36:35] parse_status,
  // [44:37] rest_offset, [45] rest_empty, [47:46] zero
  output logic [aulp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,  // is_last
  output logic                            out_tuser,  // [0] result_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aulp_pkg::CFG_W-1:0]      cfg_data    // value_count
);

  logic [aulp_pkg::CFG_W-1:0] value_count_r, value_count_nxt;
  logic                       q_valid;
  aulp_pkg::cls_t             q_cls;
  logic                       q_pop;
  logic                       out_room;
  aulp_pkg::push_t            push;

  assign cfg_ready       = 1'b1;
  assign value_count_nxt = (cfg_valid && cfg_ready) ? cfg_data : value_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_count_r <= aulp_pkg::CFG_W'(1);
    end else begin
      value_count_r <= value_count_nxt;
    end
  end

  aulp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_cls     (q_cls),
    .q_pop     (q_pop)
  );

  aulp_back #(
    .TOKEN_MAX_CHARS (TOKEN_MAX_CHARS),
    .MAX_NUMBERS     (MAX_NUMBERS),
    .LINE_BYTES      (LINE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_count (value_count_r),
    .q_valid     (q_valid),
    .q_cls       (q_cls),
    .q_pop       (q_pop),
    .out_room    (out_room),
    .push        (push)
  );

  aulp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_room   (out_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
